FILE: src/hkt_pkg.sv
// Shared types and constants for the history/killer table unit.
// No dependencies; imported by hkt_ctrl, hkt_dp and the top level.
`default_nettype none
package hkt_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_TRIED   = 2'd1,
    KIND_SUCCESS = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EXEC,
    ST_DIV,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_CLEAR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic div_start;
    logic sweep_init;
    logic sweep_rd;
    logic sweep_wr;
    logic clr_init;
    logic clr_step;
    logic out_load;
    logic trim_set;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  trim_hit;
    logic  div_done;
    logic  sweep_last;
    logic  clr_last;
    logic  out_busy;
  } sts_t;

  localparam int unsigned CountW = 16;
  localparam int unsigned MoveW  = 24;
  localparam int unsigned ScoreW = 25;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;
  localparam logic [15:0] TrimReset = 16'd32768;
  localparam logic [9:0]  ScoreScale = 10'd1000;
  localparam int unsigned NumW = 26;

endpackage
`default_nettype wire

FILE: src/hkt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module hkt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: src/hkt_ctrl.sv
// Controller state machine of the history/killer table unit.
// Depends on hkt_pkg.
`default_nettype none
module hkt_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_fire,
  input  wire hkt_pkg::sts_t sts,
  output      hkt_pkg::cmd_t cmd,
  output      logic         in_ready
);
  import hkt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_WAIT;
      ST_WAIT:     state_nxt = (sts.kind == KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
      ST_EXEC: begin
        if (sts.kind == KIND_QUERY) begin
          state_nxt = ST_DIV;
        end else if (sts.trim_hit) begin
          state_nxt = ST_SWEEP_RD;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV:      if (sts.div_done) state_nxt = ST_OUT;
      ST_SWEEP_RD: state_nxt = ST_SWEEP_WR;
      ST_SWEEP_WR: state_nxt = sts.sweep_last ? ST_OUT : ST_SWEEP_RD;
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = (sts.kind == KIND_CLEAR) ? ST_OUT : ST_IDLE;
      end
      ST_OUT:      if (!sts.out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      ST_READ: cmd.rd = 1'b1;
      ST_WAIT: cmd.clr_init = (sts.kind == KIND_CLEAR);
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.div_start = (sts.kind == KIND_QUERY);
        cmd.sweep_init = sts.trim_hit && (sts.kind != KIND_QUERY);
        cmd.trim_set = cmd.sweep_init;
      end
      ST_DIV:      ;
      ST_SWEEP_RD: cmd.sweep_rd = 1'b1;
      ST_SWEEP_WR: cmd.sweep_wr = 1'b1;
      ST_CLEAR:    cmd.clr_step = 1'b1;
      ST_OUT:      cmd.out_load = !sts.out_busy;
      default:     ;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/hkt_dp.sv
// Datapath: counter and killer memories, update, trim sweep, clear, divider.
// Depends on hkt_pkg and hkt_ram.
`default_nettype none
module hkt_dp #(
  parameter int unsigned PlySlots    = 64,
  parameter int unsigned PieceKinds  = 12,
  parameter int unsigned SquareCount = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hkt_pkg::cmd_t                cmd,
  output      hkt_pkg::sts_t                sts,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [3:0]                   in_piece,
  input  wire logic [5:0]                   in_to_square,
  input  wire logic                         in_quiet,
  input  wire logic [5:0]                   in_depth,
  input  wire logic [5:0]                   in_ply,
  input  wire logic [23:0]                  in_move,
  input  wire logic                         cfg_valid,
  input  wire logic [15:0]                  cfg_data,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [24:0]                  out_score,
  output      logic [23:0]                  out_first_killer,
  output      logic [23:0]                  out_second_killer,
  output      logic                         out_trimmed
);
  import hkt_pkg::*;

  localparam int unsigned TabSize = PieceKinds * SquareCount;
  localparam int unsigned TabAw   = (TabSize > 1) ? $clog2(TabSize) : 1;
  localparam int unsigned SqW     = (SquareCount > 1) ? $clog2(SquareCount) : 1;
  localparam int unsigned PlyAw   = (PlySlots > 1) ? $clog2(PlySlots) : 1;
  localparam int unsigned ClrCnt  = (TabSize > PlySlots) ? TabSize : PlySlots;
  localparam int unsigned ClrW    = $clog2(ClrCnt + 1);
  localparam logic [ClrW-1:0] ClrLast = ClrW'(ClrCnt - 1);
  localparam logic [TabAw-1:0] TabLast = TabAw'(TabSize - 1);

  logic [15:0] trim_r;
  kind_t       kind_r;
  logic        quiet_r, cell_ok_r, ply_ok_r, trimmed_r;
  logic [5:0]  depth_r;
  logic [TabAw-1:0] idx_r;
  logic [PlyAw-1:0] ply_r;
  logic [23:0] move_r;
  logic [11:0] dsq_r;
  logic        in_cell_ok;

  assign in_cell_ok = (32'(in_piece) < PieceKinds) && (32'(in_to_square) < SquareCount);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= TrimReset;
    end else if (cfg_valid) begin
      trim_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_QUERY;
    end else if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quiet_r   <= in_quiet;
      cell_ok_r <= in_cell_ok;
      ply_ok_r  <= 32'(in_ply) < PlySlots;
      depth_r   <= in_depth;
      idx_r     <= in_cell_ok
                   ? TabAw'(32'(in_piece) * SquareCount + 32'(in_to_square[SqW-1:0]))
                   : '0;
      ply_r     <= PlyAw'(in_ply);
      move_r    <= in_move;
    end
    if (cmd.rd) begin
      dsq_r <= depth_r * depth_r;
    end
  end

  // counter memories
  logic [TabAw-1:0] sw_addr_r;
  logic [ClrW-1:0]  clr_r;
  logic             sweeping;
  logic [TabAw-1:0] t_addr;
  logic             s_we, t_we;
  logic [15:0]      s_wd, t_wd, s_rd, t_rd;

  logic [16:0] bump_sum;
  logic [15:0] bump_val;
  logic        rec_ok, is_tried, is_succ;

  assign is_tried = kind_r == KIND_TRIED;
  assign is_succ  = kind_r == KIND_SUCCESS;
  assign rec_ok   = quiet_r && cell_ok_r && (is_tried || is_succ);
  assign bump_sum = 17'(is_tried ? t_rd : s_rd) + 17'(dsq_r);
  assign bump_val = bump_sum[16] ? CountMax : bump_sum[15:0];
  assign sweeping = cmd.sweep_rd || cmd.sweep_wr;

  always_comb begin
    t_addr = idx_r;
    s_we = 1'b0;
    t_we = 1'b0;
    s_wd = bump_val;
    t_wd = bump_val;
    if (sweeping) begin
      t_addr = sw_addr_r;
      s_we = cmd.sweep_wr;
      t_we = cmd.sweep_wr;
      s_wd = {1'b0, s_rd[15:1]};
      t_wd = {1'b0, t_rd[15:1]};
    end else if (cmd.clr_step) begin
      t_addr = TabAw'(clr_r);
      s_we = 32'(clr_r) < TabSize;
      t_we = s_we;
      s_wd = '0;
      t_wd = '0;
    end else if (cmd.exec && rec_ok) begin
      s_we = is_succ;
      t_we = is_tried;
    end
  end

  hkt_ram #(.Width(CountW), .Depth(TabSize)) u_succ (
    .clk(clk), .we(s_we), .addr(t_addr), .wdata(s_wd), .rdata(s_rd)
  );
  hkt_ram #(.Width(CountW), .Depth(TabSize)) u_tried (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd)
  );

  // killer memories
  logic [PlyAw-1:0] k_addr;
  logic             k_we;
  logic [23:0]      k1_wd, k2_wd, k1_rd, k2_rd;
  logic             kill_upd;

  assign kill_upd = cmd.exec && is_succ && quiet_r && ply_ok_r && (move_r != k1_rd);

  always_comb begin
    k_addr = ply_r;
    k_we = kill_upd;
    k1_wd = move_r;
    k2_wd = k1_rd;
    if (cmd.clr_step) begin
      k_addr = PlyAw'(clr_r);
      k_we = 32'(clr_r) < PlySlots;
      k1_wd = '0;
      k2_wd = '0;
    end
  end

  hkt_ram #(.Width(MoveW), .Depth(PlySlots)) u_k1 (
    .clk(clk), .we(k_we), .addr(k_addr), .wdata(k1_wd), .rdata(k1_rd)
  );
  hkt_ram #(.Width(MoveW), .Depth(PlySlots)) u_k2 (
    .clk(clk), .we(k_we), .addr(k_addr), .wdata(k2_wd), .rdata(k2_rd)
  );

  logic [23:0] kf_r, ks_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kf_r <= kill_upd ? move_r : k1_rd;
      ks_r <= kill_upd ? k1_rd : k2_rd;
    end
    if (cmd.sweep_init) begin
      sw_addr_r <= '0;
    end else if (cmd.sweep_wr) begin
      sw_addr_r <= sw_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      trimmed_r <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        clr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.load) begin
        trimmed_r <= 1'b0;
      end else if (cmd.trim_set) begin
        trimmed_r <= 1'b1;
      end
    end
  end

  // restoring divider: num / (tried + 1)
  logic [NumW-1:0]  num_r;
  logic [16:0]      den_r;
  logic [16:0]      rem_r;
  logic [4:0]       dcnt_r;
  logic             dbusy_r;
  logic [17:0]      rem_sh;
  logic [17:0]      rem_sub;

  assign rem_sh  = {rem_r, num_r[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == 5'(NumW - 1)) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r  <= cell_ok_r ? s_rd * ScoreScale : '0;
      den_r  <= 17'(t_rd) + 17'd1;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (!rem_sub[17]) begin
        rem_r <= rem_sub[16:0];
        num_r <= {num_r[NumW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[16:0];
        num_r <= {num_r[NumW-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_score <= (kind_r == KIND_QUERY)
                   ? (num_r[NumW-1] ? {ScoreW{1'b1}} : num_r[ScoreW-1:0]) : '0;
      out_first_killer  <= (ply_ok_r && kind_r != KIND_CLEAR) ? kf_r : '0;
      out_second_killer <= (ply_ok_r && kind_r != KIND_CLEAR) ? ks_r : '0;
      out_trimmed <= trimmed_r;
    end
  end

  assign sts.kind       = kind_r;
  assign sts.trim_hit   = rec_ok && (bump_val > trim_r);
  assign sts.div_done   = dbusy_r && dcnt_r == 5'(NumW - 1);
  assign sts.sweep_last = sw_addr_r == TabLast;
  assign sts.clr_last   = clr_r == ClrLast;
  assign sts.out_busy   = out_valid && !out_ready;
endmodule
`default_nettype wire

FILE: src/history_killer_table_unit.sv
// Top level of the history/killer table unit.
// Depends on hkt_pkg, hkt_ctrl, hkt_dp.
// One word at a time. A record steps through read, wait, execute and
// output states; a query adds a 26-bit restoring divider (one quotient bit
// per cycle); a record that trims walks all counters, reading then writing
// each entry; and a clear writes 0 over max(768,64) entries, one per cycle.
// After reset the same clearing pass runs before the first word is
// accepted. A result waits in an output register; configuration is
// taken at any time.
`default_nettype none
module history_killer_table_unit #(
  parameter int unsigned PLY_SLOTS    = 64,
  parameter int unsigned PIECE_KINDS  = 12,
  parameter int unsigned SQUARE_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [3:0]  in_piece,
  input  wire logic [5:0]  in_to_square,
  input  wire logic        in_quiet,
  input  wire logic [5:0]  in_depth,
  input  wire logic [5:0]  in_ply,
  input  wire logic [23:0] in_move,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [24:0] out_score,
  output      logic [23:0] out_first_killer,
  output      logic [23:0] out_second_killer,
  output      logic        out_trimmed,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import hkt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  hkt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .sts(sts), .cmd(cmd),
    .in_ready(in_ready)
  );

  hkt_dp #(
    .PlySlots(PLY_SLOTS), .PieceKinds(PIECE_KINDS), .SquareCount(SQUARE_COUNT)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_piece(in_piece), .in_to_square(in_to_square),
    .in_quiet(in_quiet), .in_depth(in_depth), .in_ply(in_ply), .in_move(in_move),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_score(out_score),
    .out_first_killer(out_first_killer), .out_second_killer(out_second_killer),
    .out_trimmed(out_trimmed)
  );
endmodule
`default_nettype wire

FILE: src/hkt_checker.sv
// Port-level checks for the history/killer table unit, bound to the top level.
// No package dependencies.
`default_nettype none
module hkt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_kind,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [24:0] out_score,
  input wire logic [23:0] out_first_killer,
  input wire logic [23:0] out_second_killer,
  input wire logic        out_trimmed
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_out_fields_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_killer) && $stable(out_second_killer)
    && $stable(out_trimmed))
    else $error("result fields changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_kind))
    else $error("input word dropped or changed while waiting");
endmodule

bind history_killer_table_unit hkt_checker u_hkt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
  .out_score(out_score), .out_first_killer(out_first_killer),
  .out_second_killer(out_second_killer), .out_trimmed(out_trimmed)
);
`default_nettype wire
